// File: hw/rtl/srts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table range search package
// Shared widths, codes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package srts_pkg;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int SLOT_W = 10;
    localparam int OUT_W  = 11;
    localparam int IDX_W  = 12;

    typedef logic signed [IDX_W-1:0] t_idx;

    localparam t_idx IDX_NONE = -12'sd1;
    localparam t_idx IDX_ZERO = 12'sd0;
    localparam t_idx IDX_ONE  = 12'sd1;

    // Transaction kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOW_ISSUE,
        S_LOW_PROBE,
        S_HIGH_ISSUE,
        S_HIGH_PROBE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic write;    // store the input entry
        logic load;     // capture target, set bounds for first search
        logic probe;    // read data is valid for r_mid, update bounds
        logic upper;    // last-match search mode
        logic restart;  // save first result, reset bounds for second search
        logic finish;   // register result and raise the strobe
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic span_done;  // bounds have crossed after this cycle's update
    } t_dp_stat;

endpackage

// File: hw/rtl/srts_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/srts_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table range search controller
// Sequences the lower-bound search, then the upper-bound search.
// ----------------------------------------------------------------------------
module srts_ctrl
    import srts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_kind,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_kind == KIND_SEARCH) begin
                    n_state = S_LOW_ISSUE;
                end
            end
            S_LOW_ISSUE: begin
                n_state = i_stat.span_done ? S_HIGH_ISSUE : S_LOW_PROBE;
            end
            S_LOW_PROBE: begin
                if (i_stat.span_done) begin
                    n_state = S_HIGH_ISSUE;
                end
            end
            S_HIGH_ISSUE: begin
                n_state = i_stat.span_done ? S_IDLE : S_HIGH_PROBE;
            end
            S_HIGH_PROBE: begin
                if (i_stat.span_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_cmd.write = start && i_kind == KIND_WRITE;
                o_cmd.load  = start && i_kind == KIND_SEARCH;
            end
            S_LOW_ISSUE: begin
                o_cmd.restart = i_stat.span_done;
            end
            S_LOW_PROBE: begin
                o_cmd.probe   = 1'b1;
                o_cmd.restart = i_stat.span_done;
            end
            S_HIGH_ISSUE: begin
                o_cmd.upper  = 1'b1;
                o_cmd.finish = i_stat.span_done;
            end
            S_HIGH_PROBE: begin
                o_cmd.upper  = 1'b1;
                o_cmd.probe  = 1'b1;
                o_cmd.finish = i_stat.span_done;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Checks
    a_finish_in_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> o_cmd.upper && !o_cmd.restart)
        else $error("finish outside the upper-bound search");

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("controller not idle after finish");

    a_restart_to_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.restart |=> r_state == S_HIGH_ISSUE)
        else $error("restart did not start the upper-bound search");

endmodule

// File: hw/rtl/srts_dpath.sv
// ----------------------------------------------------------------------------
// Sorted table range search datapath
// Table memory, count register, search bounds, probe compare and results.
// ----------------------------------------------------------------------------
module srts_dpath
    import srts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic [SLOT_W-1:0]       i_slot,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_first_index,
    output logic signed [OUT_W-1:0] o_last_index
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]        r_entry_count;
    logic signed [VAL_W-1:0] r_target;
    t_idx                    r_lo;
    t_idx                    r_hi;
    t_idx                    r_mid;
    t_idx                    r_n;
    t_idx                    r_found;
    t_idx                    r_first;
    logic                    r_done;
    logic signed [OUT_W-1:0] r_first_out;
    logic signed [OUT_W-1:0] r_last_out;

    t_idx                    n_lo;
    t_idx                    n_hi;
    t_idx                    n_found;
    t_idx                    next_mid;
    t_idx                    span;
    t_idx                    cnt_n;
    logic [CNT_W-1:0]        cnt_clamp;
    logic signed [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0]        rd_raw;
    logic [31:0]             slot_ext;
    logic [31:0]             mid_ext;
    logic                    wr_en;
    logic                    hit;
    logic                    go_left;

    // Table memory
    assign slot_ext = 32'(i_slot);
    assign mid_ext  = 32'($unsigned(next_mid));
    assign wr_en    = i_cmd.write && (slot_ext < 32'(DEPTH));

    srts_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (mid_ext[AW-1:0]),
        .o_rdata (rd_raw)
    );

    assign rd_data = $signed(rd_raw);

    // Entry count clamped to the table depth
    always_comb begin
        cnt_clamp = r_entry_count;
        if (32'(r_entry_count) > 32'(DEPTH)) begin
            cnt_clamp = CNT_W'(DEPTH);
        end
        cnt_n = $signed({1'b0, cnt_clamp});
    end

    // Probe compare, bound update and next midpoint
    always_comb begin
        hit     = (r_target == rd_data);
        go_left = i_cmd.upper ? (r_target < rd_data) : (r_target <= rd_data);
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_found = r_found;
        if (i_cmd.probe) begin
            if (hit) begin
                n_found = r_mid;
            end
            if (go_left) begin
                n_hi = r_mid - IDX_ONE;
            end else begin
                n_lo = r_mid + IDX_ONE;
            end
        end
        span     = n_hi - n_lo;
        next_mid = n_hi - (span >>> 1);
    end

    assign o_stat.span_done = (n_lo > n_hi);

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Search registers
    always_ff @(posedge i_clk) begin
        r_mid <= next_mid;
        if (i_cmd.load) begin
            r_target <= i_value;
            r_n      <= cnt_n;
            r_lo     <= IDX_ZERO;
            r_hi     <= cnt_n - IDX_ONE;
            r_found  <= IDX_NONE;
        end else if (i_cmd.restart) begin
            r_first <= n_found;
            r_lo    <= IDX_ZERO;
            r_hi    <= r_n - IDX_ONE;
            r_found <= IDX_NONE;
        end else begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_found <= n_found;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_first_out <= r_first[OUT_W-1:0];
            r_last_out  <= n_found[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_done        = r_done;
    assign o_first_index = r_first_out;
    assign o_last_index  = r_last_out;

endmodule

// File: hw/rtl/sorted_table_range_search_top.sv
// ----------------------------------------------------------------------------
// Sorted table range search, top level
// Table of signed entries with first/last-match binary search.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+---------------------------------------
//   input    | start, busy            | i_kind, i_slot, i_value
//   result   | o_done (1-cycle strobe)| o_first_index, o_last_index
//   config   | i_cfg_we               | i_cfg_wdata (entry_count)
//
// A write transaction gives no result.
// A search runs a lower-bound and then an upper-bound binary search, where
// each probe is one table read through the single read port of the table.
// One search is in flight at a time; busy stays high until the result strobe.
// Synchronous active-low reset clears the controller, the count and the
// strobe; table contents are undefined until written.
// The result receiver cannot stall: o_done is a 1-cycle strobe, and the indices hold until another search finishes.
// ----------------------------------------------------------------------------
module sorted_table_range_search_top
    import srts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_kind,
    input  logic [SLOT_W-1:0]       i_slot,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_first_index,
    output logic signed [OUT_W-1:0] o_last_index
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller
    srts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    // Datapath
    srts_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_done        (o_done),
        .o_first_index (o_first_index),
        .o_last_index  (o_last_index)
    );

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe not aligned with end of search");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind == KIND_SEARCH |=> busy && !o_done)
        else $error("search transaction did not start the search");

endmodule
